### hdl/i2c_mws_pkg.sv
package i2c_mws_pkg;

   // Width of the byte counters (remaining and sent)
   localparam int unsigned COUNT_BITS = 8;

   // Register reset values
   localparam logic [7:0]  RETRY_LIMIT_RESET   = 8'd200;
   localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd1000;

   // Register indexes
   localparam logic CSR_RETRY_LIMIT   = 1'b0;
   localparam logic CSR_TIMEOUT_LIMIT = 1'b1;

   // Request codes
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Bus commands
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_SEND  = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   // Masked bus status codes
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_SLA_ACK   = 8'h18;
   localparam logic [7:0] ST_SLA_NACK  = 8'h20;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_START  = 4'b0010,
      PH_SELECT = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] dev_addr;
      logic [7:0] byte_count;
      logic [7:0] bus_status;
      logic [7:0] next_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] bus_cmd;
      logic [7:0] tx_byte;
      logic       done_res;
      logic       failed;
      logic [7:0] bytes_sent;
   } rsp_item_type;

endpackage

### hdl/i2c_master_write_sequencer.sv
// Channel   Ports                          Direction  Moves
// request   req_valid/req_ready/req_data   in         one event: begin, bus step or tick
// response  rsp_valid/rsp_ready/rsp_data   out        one bus command and status per event
// csr       csr_we/csr_index/csr_wdata     in         retry and timeout limits
//
// Each transaction passes from acceptance through the input register, then
// through the sequencer logic into the output register.
// One transaction per cycle is sustained unless the response stalls; the state update is a single pass.
// Reset is synchronous and returns the sequencer to idle with both limits at
// their defaults. A stalled response holds the pipeline; req_ready then drops.
module i2c_master_write_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  i2c_mws_pkg::req_item_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output i2c_mws_pkg::rsp_item_type  rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [15:0]                csr_wdata
);
   import i2c_mws_pkg::*;

   // Configuration registers
   logic [7:0]  retry_limit_ff;
   logic [15:0] timeout_limit_ff;

   // Pipeline registers
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         advance;

   // Sequencer state
   phase_type             phase_ff, phase_in;
   logic [7:0]            attempt_count_ff, attempt_count_in;
   logic [15:0]           wait_count_ff, wait_count_in;
   logic [COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic [COUNT_BITS-1:0] sent_count_ff, sent_count_in;
   logic [7:0]            select_byte_ff, select_byte_in;

   logic                  do_attempt;
   logic [7:0]            attempt_base;
   logic [COUNT_BITS-1:0] remaining_dec;

   // Handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   assign remaining_dec = remaining_ff - COUNT_BITS'(1);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff   <= RETRY_LIMIT_RESET;
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata[7:0];
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Sequencer: next state and response for the transaction in the input register
   always_comb begin
      phase_in         = phase_ff;
      attempt_count_in = attempt_count_ff;
      wait_count_in    = wait_count_ff;
      remaining_in     = remaining_ff;
      sent_count_in    = sent_count_ff;
      select_byte_in   = select_byte_ff;
      do_attempt       = 1'b0;
      attempt_base     = attempt_count_ff;
      out_item_in.bus_cmd  = CMD_NONE;
      out_item_in.tx_byte  = 8'd0;
      out_item_in.done_res = 1'b0;
      out_item_in.failed   = 1'b0;

      priority if (in_item_ff.req_type == REQ_BEGIN) begin
         // new transfer, any running one is dropped
         select_byte_in = in_item_ff.dev_addr;
         remaining_in   = COUNT_BITS'(in_item_ff.byte_count);
         sent_count_in  = '0;
         do_attempt     = 1'b1;
         attempt_base   = 8'd0;
      end else if (in_item_ff.req_type == REQ_TICK && phase_ff != PH_IDLE) begin
         if (wait_count_ff >= timeout_limit_ff) begin
            phase_in             = PH_IDLE;
            out_item_in.done_res = 1'b1;
            out_item_in.failed   = 1'b1;
         end else begin
            wait_count_in = wait_count_ff + 16'd1;
         end
      end else if (in_item_ff.req_type == REQ_STEP) begin
         unique case (phase_ff)
            PH_START: begin
               if (in_item_ff.bus_status == ST_START ||
                   in_item_ff.bus_status == ST_RESTART) begin
                  wait_count_in       = '0;
                  phase_in            = PH_SELECT;
                  out_item_in.bus_cmd = CMD_SEND;
                  out_item_in.tx_byte = select_byte_ff;
               end else if (in_item_ff.bus_status == ST_ARB_LOST) begin
                  wait_count_in       = '0;
                  out_item_in.bus_cmd = CMD_START;
               end else begin
                  // bad start, give up without STOP
                  phase_in             = PH_IDLE;
                  out_item_in.done_res = 1'b1;
                  out_item_in.failed   = 1'b1;
               end
            end
            PH_SELECT: begin
               if (in_item_ff.bus_status == ST_SLA_ACK) begin
                  if (remaining_ff != '0) begin
                     wait_count_in       = '0;
                     phase_in            = PH_DATA;
                     out_item_in.bus_cmd = CMD_SEND;
                     out_item_in.tx_byte = in_item_ff.next_byte;
                  end else begin
                     phase_in             = PH_IDLE;
                     out_item_in.bus_cmd  = CMD_STOP;
                     out_item_in.done_res = 1'b1;
                  end
               end else if (in_item_ff.bus_status == ST_SLA_NACK) begin
                  do_attempt = 1'b1;
               end else if (in_item_ff.bus_status == ST_ARB_LOST) begin
                  wait_count_in       = '0;
                  phase_in            = PH_START;
                  out_item_in.bus_cmd = CMD_START;
               end else begin
                  phase_in             = PH_IDLE;
                  out_item_in.bus_cmd  = CMD_STOP;
                  out_item_in.done_res = 1'b1;
                  out_item_in.failed   = 1'b1;
               end
            end
            PH_DATA: begin
               if (in_item_ff.bus_status == ST_DATA_ACK) begin
                  sent_count_in = sent_count_ff + COUNT_BITS'(1);
                  remaining_in  = remaining_dec;
                  if (remaining_dec != '0) begin
                     wait_count_in       = '0;
                     out_item_in.bus_cmd = CMD_SEND;
                     out_item_in.tx_byte = in_item_ff.next_byte;
                  end else begin
                     phase_in             = PH_IDLE;
                     out_item_in.bus_cmd  = CMD_STOP;
                     out_item_in.done_res = 1'b1;
                  end
               end else begin
                  // data NACK, lost arbitration or anything else
                  phase_in             = PH_IDLE;
                  out_item_in.bus_cmd  = CMD_STOP;
                  out_item_in.done_res = 1'b1;
                  out_item_in.failed   = 1'b1;
               end
            end
            default: ;
         endcase
      end else begin
         // idle events and unused codes answer with no command
      end

      // counted attempt: START, or failure without STOP once the limit is reached
      if (do_attempt) begin
         attempt_count_in = attempt_base;
         if (attempt_base >= retry_limit_ff) begin
            phase_in             = PH_IDLE;
            out_item_in.done_res = 1'b1;
            out_item_in.failed   = 1'b1;
         end else begin
            attempt_count_in    = attempt_base + 8'd1;
            wait_count_in       = '0;
            phase_in            = PH_START;
            out_item_in.bus_cmd = CMD_START;
         end
      end

      out_item_in.bytes_sent = 8'(sent_count_in);
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         phase_ff         <= PH_IDLE;
         attempt_count_ff <= '0;
         wait_count_ff    <= '0;
         remaining_ff     <= '0;
         sent_count_ff    <= '0;
         select_byte_ff   <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff     <= 1'b1;
            phase_ff         <= phase_in;
            attempt_count_ff <= attempt_count_in;
            wait_count_ff    <= wait_count_in;
            remaining_ff     <= remaining_in;
            sent_count_ff    <= sent_count_in;
            select_byte_ff   <= select_byte_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

`ifndef ASSERT_OFF
   a_fail_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failed |-> rsp_data.done_res)
      else $error("failure reported without end of transfer");

   a_tx_only_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_cmd != CMD_SEND |-> rsp_data.tx_byte == 8'd0)
      else $error("tx_byte set without a send command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      advance && out_item_in.done_res |=> phase_ff == PH_IDLE)
      else $error("transfer ended but sequencer not idle");
`endif

endmodule
